/* sv/sji_pkg.sv */
`default_nettype none
package sji_pkg;

  localparam int HistoryDepth = 8;
  localparam int FractionBits = 16;
  localparam int CfgIdxW = 1;

  localparam logic [31:0] DelayReset = 32'd100000;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_SNAP   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [CfgIdxW-1:0] REG_DELAY = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_PASS  = 1'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SEARCH,
    ST_READ_A,
    ST_READ_B,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic store;
    logic snap_clear;
    logic search_start;
    logic search_step;
    logic read_a;
    logic read_b;
    logic div_start;
    logic div_step;
    logic mul_step;
    logic sum_step;
    logic load_pass;
    logic load_blend;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       drop_update;
    logic       tick_ok;
    logic       search_done;
    logic       div_done;
    logic       mul_done;
  } dp_status_t;

endpackage
`default_nettype wire

/* sv/sji_ctrl.sv */
`default_nettype none
module sji_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire                       out_stall,
  input  wire                       passthrough,
  input  sji_pkg::dp_status_t       status,
  output sji_pkg::dp_cmd_t          cmd
);

  sji_pkg::state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sji_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    out_valid_next = out_valid && out_stall;
    in_stall = (state != sji_pkg::ST_IDLE);
    unique case (state)
      sji_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = sji_pkg::ST_DECIDE;
        end
      end
      sji_pkg::ST_DECIDE: begin
        state_next = sji_pkg::ST_IDLE;
        if (status.cmd == sji_pkg::CMD_UPDATE || status.cmd == sji_pkg::CMD_SNAP) begin
          if (passthrough) begin
            if (!out_valid) begin
              cmd.load_pass = 1'b1;
              out_valid_next = 1'b1;
            end else begin
              state_next = sji_pkg::ST_DECIDE;
            end
          end else if (status.cmd == sji_pkg::CMD_SNAP) begin
            if (!out_valid) begin
              cmd.snap_clear = 1'b1;
              cmd.store = 1'b1;
              cmd.load_pass = 1'b1;
              out_valid_next = 1'b1;
            end else begin
              state_next = sji_pkg::ST_DECIDE;
            end
          end else if (!status.drop_update) begin
            cmd.store = 1'b1;
          end
        end else if (status.cmd == sji_pkg::CMD_TICK && !passthrough && status.tick_ok) begin
          cmd.search_start = 1'b1;
          state_next = sji_pkg::ST_SEARCH;
        end
      end
      sji_pkg::ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_done) state_next = sji_pkg::ST_READ_A;
      end
      sji_pkg::ST_READ_A: begin
        cmd.read_a = 1'b1;
        state_next = sji_pkg::ST_READ_B;
      end
      sji_pkg::ST_READ_B: begin
        cmd.read_b = 1'b1;
        cmd.div_start = 1'b1;
        state_next = sji_pkg::ST_DIV;
      end
      sji_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = sji_pkg::ST_MUL;
      end
      sji_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        state_next = sji_pkg::ST_SUM;
      end
      sji_pkg::ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.mul_done) state_next = sji_pkg::ST_OUT;
        else state_next = sji_pkg::ST_MUL;
      end
      sji_pkg::ST_OUT: begin
        if (!out_valid) begin
          cmd.load_blend = 1'b1;
          out_valid_next = 1'b1;
          state_next = sji_pkg::ST_IDLE;
        end
      end
      default: state_next = sji_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/sji_datapath.sv */
`default_nettype none
module sji_datapath #(
  parameter int HISTORY_DEPTH = sji_pkg::HistoryDepth,
  parameter int FRACTION_BITS = sji_pkg::FractionBits
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire          [1:0]  in_cmd,
  input  wire          [31:0] in_time,
  input  wire signed   [31:0] in_comp [6],
  input  wire          [31:0] interp_delay,
  input  sji_pkg::dp_cmd_t    cmd,
  output sji_pkg::dp_status_t status,
  output logic signed  [31:0] out_comp [6]
);

  localparam int IdxW = $clog2(HISTORY_DEPTH);
  localparam int CntW = $clog2(HISTORY_DEPTH + 1);
  localparam int FW = FRACTION_BITS + 1;
  localparam int QW = 32 + FRACTION_BITS;
  localparam int QCW = $clog2(QW + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(HISTORY_DEPTH);

  // sample memory: time plus six components per slot
  logic [32*7-1:0] mem [HISTORY_DEPTH];
  logic [32*7-1:0] rd_data;

  logic [1:0] cur_cmd;
  logic [31:0] cur_time;
  logic signed [31:0] cur_comp [6];

  logic [IdxW-1:0] head;
  logic [CntW-1:0] count;
  logic [31:0] newest;
  logic have;

  logic [31:0] rt;
  logic [CntW-1:0] k;
  logic [IdxW-1:0] sa, sb;
  logic search_done;
  logic [31:0] ta;
  logic signed [31:0] ca [6];
  logic signed [31:0] cb [6];

  logic [31:0] dden;
  logic [QW-1:0] quo;
  logic [32:0] rem;
  logic [QCW-1:0] div_cnt;
  logic div_busy;
  logic div_init;
  logic [FW-1:0] frac;

  logic [2:0] comp_i;
  logic signed [32+FW:0] prod;
  logic signed [31:0] res [6];

  logic [IdxW-1:0] rd_addr;
  logic [IdxW-1:0] wr_slot;
  logic [IdxW-1:0] head_w;
  logic [CntW-1:0] count_w;

  function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] h,
                                                input logic [CntW-1:0] o);
    logic [CntW:0] s;
    s = (CntW+1)'(h) + (CntW+1)'(o);
    if (s >= (CntW+1)'(HISTORY_DEPTH)) s = s - (CntW+1)'(HISTORY_DEPTH);
    return s[IdxW-1:0];
  endfunction

  always_comb begin
    head_w = cmd.snap_clear ? '0 : head;
    count_w = cmd.snap_clear ? '0 : count;
    if (count_w >= DepthC) begin
      head_w = slot_of(head_w, CntW'(1));
      count_w = DepthC - CntW'(1);
    end
    wr_slot = slot_of(head_w, count_w);
  end

  always_comb begin
    rd_addr = slot_of(head, k);
    if (cmd.read_a) rd_addr = sa;
    if (cmd.read_b) rd_addr = sb;
  end

  always_ff @(posedge clk) begin
    if (cmd.store)
      mem[wr_slot] <= {cur_comp[5], cur_comp[4], cur_comp[3],
                       cur_comp[2], cur_comp[1], cur_comp[0], cur_time};
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_cmd <= in_cmd;
      cur_time <= in_time;
      for (int i = 0; i < 6; i++) cur_comp[i] <= in_comp[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
      newest <= '0;
      have <= 1'b0;
    end else if (cmd.store) begin
      head <= head_w;
      count <= count_w + CntW'(1);
      newest <= cur_time;
      have <= 1'b1;
    end
  end

  // search: read slot k, its data lands in rd_data on the next cycle
  logic srch_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      search_done <= 1'b0;
      srch_pend <= 1'b0;
    end else if (cmd.search_start) begin
      rt <= newest - interp_delay;
      k <= CntW'(1);
      sa <= head;
      sb <= slot_of(head, count - CntW'(1));
      search_done <= 1'b0;
      srch_pend <= 1'b0;
    end else if (cmd.search_step && !search_done) begin
      if (srch_pend) begin
        srch_pend <= 1'b0;
        if (rd_data[31:0] >= rt) begin
          sa <= slot_of(head, k - CntW'(1));
          sb <= slot_of(head, k);
          search_done <= 1'b1;
        end else if (k + CntW'(1) >= count) begin
          search_done <= 1'b1;
        end else begin
          k <= k + CntW'(1);
        end
      end else begin
        srch_pend <= 1'b1;
      end
    end
  end

  // a data arrives with read_b, b data in the cycle after div_start (with div_init)
  always_ff @(posedge clk) begin
    if (cmd.read_b) begin
      ta <= rd_data[31:0];
      for (int i = 0; i < 6; i++) ca[i] <= rd_data[32*(i+1) +: 32];
    end
    if (div_init) begin
      for (int i = 0; i < 6; i++) cb[i] <= rd_data[32*(i+1) +: 32];
    end
  end

  // restoring divider, one quotient bit per cycle; b time read straight from rd_data
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_init <= 1'b0;
    end else if (cmd.div_start) begin
      div_init <= 1'b1;
      div_busy <= 1'b0;
    end else if (div_init) begin
      div_init <= 1'b0;
      dden <= rd_data[31:0] - ta;
      rem <= '0;
      quo <= {rt - ta, {FRACTION_BITS{1'b0}}};
      div_cnt <= QCW'(QW);
      if (rd_data[31:0] <= ta || rt <= ta) begin
        frac <= '0;
        div_busy <= 1'b0;
      end else if (rt - ta >= rd_data[31:0] - ta) begin
        frac <= FW'(1) << FRACTION_BITS;
        div_busy <= 1'b0;
      end else begin
        div_busy <= 1'b1;
      end
    end else if (div_busy) begin
      if ({rem[31:0], quo[QW-1]} >= {1'b0, dden}) begin
        rem <= {rem[31:0], quo[QW-1]} - {1'b0, dden};
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= {rem[31:0], quo[QW-1]};
        quo <= {quo[QW-2:0], 1'b0};
      end
      div_cnt <= div_cnt - QCW'(1);
      if (div_cnt == QCW'(1)) begin
        div_busy <= 1'b0;
        if ({rem[31:0], quo[QW-1]} >= {1'b0, dden})
          frac <= FW'({quo[QW-2:0], 1'b1});
        else
          frac <= FW'({quo[QW-2:0], 1'b0});
      end
    end
  end

  // blends: one multiply per component, then add with floor shift
  always_ff @(posedge clk) begin
    if (cmd.div_start) comp_i <= '0;
    if (cmd.mul_step)
      prod <= ($signed({cb[comp_i][31], cb[comp_i]}) - $signed({ca[comp_i][31], ca[comp_i]}))
              * $signed({1'b0, frac});
    if (cmd.sum_step) begin
      res[comp_i] <= 32'(ca[comp_i] + 32'(prod >>> FRACTION_BITS));
      comp_i <= comp_i + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pass)
      for (int i = 0; i < 6; i++) out_comp[i] <= cur_comp[i];
    else if (cmd.load_blend)
      for (int i = 0; i < 6; i++) out_comp[i] <= res[i];
  end

  always_comb begin
    status.cmd = cur_cmd;
    status.drop_update = have && (cur_time < newest);
    status.tick_ok = (count >= CntW'(2)) && (newest > interp_delay);
    status.search_done = search_done;
    status.div_done = !div_busy && !div_init && !cmd.div_start;
    status.mul_done = cmd.sum_step && (comp_i == 3'd5);
  end

endmodule
`default_nettype wire

/* sv/snapshot_jitter_interpolator_core.sv */
`default_nettype none
// Snapshot jitter buffer with interpolation.
// Input channel (in_valid/in_stall) carries one command per transaction:
// update stores a sample unless it is older than the newest, snap clears history,
// stores and emits it, tick emits a blend of the two samples that bracket
// newest time minus delay; in pass-through mode update and snap emit the
// sample unstored and tick is ignored. Output channel (out_valid/out_stall)
// carries one transform per result. Config port (cfg_we, cfg_index, cfg_data)
// writes the render delay (0) and pass-through mode (1); write only while idle.
// A tick searches the history, reads the two samples that bracket the render
// time, divides serially (cut short when the fraction clamps) and blends each
// component in turn; the serial divider and the single-port sample memory set
// its length. One item at a time: in_stall is high while an item is in work.
// A result stays on the output register until taken; while out_stall is
// high the block still takes one more transaction and holds it until the
// output register frees.
// Reset empties the history and restores the register defaults; the sample
// memory itself is not cleared, empty slots are never read.
module snapshot_jitter_interpolator_core #(
  parameter int HISTORY_DEPTH = sji_pkg::HistoryDepth,
  parameter int FRACTION_BITS = sji_pkg::FractionBits
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire         [1:0]  cmd,
  input  wire         [31:0] sample_time,
  input  wire signed  [31:0] pos_x,
  input  wire signed  [31:0] pos_y,
  input  wire signed  [31:0] pos_z,
  input  wire signed  [31:0] rot_x,
  input  wire signed  [31:0] rot_y,
  input  wire signed  [31:0] rot_z,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_rot_x,
  output logic signed [31:0] out_rot_y,
  output logic signed [31:0] out_rot_z,
  input  wire                cfg_we,
  input  wire [sji_pkg::CfgIdxW-1:0] cfg_index,
  input  wire         [31:0] cfg_data
);

  logic [31:0] interp_delay;
  logic passthrough;
  sji_pkg::dp_cmd_t dcmd;
  sji_pkg::dp_status_t dstat;
  logic signed [31:0] in_comp [6];
  logic signed [31:0] out_comp [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_delay <= sji_pkg::DelayReset;
      passthrough <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sji_pkg::REG_DELAY: interp_delay <= cfg_data;
        sji_pkg::REG_PASS:  passthrough <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_comp[0] = pos_x;
  assign in_comp[1] = pos_y;
  assign in_comp[2] = pos_z;
  assign in_comp[3] = rot_x;
  assign in_comp[4] = rot_y;
  assign in_comp[5] = rot_z;

  sji_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .passthrough(passthrough), .status(dstat), .cmd(dcmd)
  );

  sji_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk(clk), .rst(rst),
    .in_cmd(cmd), .in_time(sample_time), .in_comp(in_comp),
    .interp_delay(interp_delay), .cmd(dcmd), .status(dstat), .out_comp(out_comp)
  );

  assign out_pos_x = out_comp[0];
  assign out_pos_y = out_comp[1];
  assign out_pos_z = out_comp[2];
  assign out_rot_x = out_comp[3];
  assign out_rot_y = out_comp[4];
  assign out_rot_z = out_comp[5];

endmodule
`default_nettype wire

/* sv/sji_checker.sv */
`default_nettype none
module sji_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire [31:0] out_pos_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x))
    else $error("output dropped while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind snapshot_jitter_interpolator_core sji_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_pos_x(out_pos_x)
);
`default_nettype wire
